### hdl/lzs_pkg.sv
// shared types and constants for the lzs stream decompressor
package lzs_pkg;

    localparam int OFF_W      = 11;
    localparam int LEN_W      = 7;
    localparam int RESULT_CAP = 64;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [1:0] COPY_SHORT = 2'd0;
    localparam logic [1:0] COPY_MID   = 2'd1;
    localparam logic [1:0] COPY_EXT   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       consume;
        logic       acc_shift;
        logic       fstart;
        logic [3:0] fbits;
        logic       off_load;
        logic       ext_init;
        logic       ext_add;
        logic       copy_start;
        logic [1:0] copy_sel;
        logic       copy_rd;
        logic       copy_wr;
        logic       lit_wr;
        logic       emit;
        logic [1:0] emit_kind;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic             bit_in;
        logic [OFF_W-1:0] acc_new;
        logic             fdone;
        logic             bcnt_last;
        logic             bcnt_zero;
        logic             off_bad;
        logic             ext_sum_over;
        logic             ext_add_over;
        logic             copy_last;
        logic             emit_ok;
        logic             flush_ok;
    } sts_t;

endpackage

### hdl/lzs_ram.sv
// generic single-write single-read ram with registered read
module lzs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### hdl/lzs_ctrl.sv
// token parser and sequencing state machine
module lzs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  lzs_pkg::sts_t st,
    output lzs_pkg::cmd_t cmd
);
    import lzs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIT   = 3'd1;
    localparam logic [2:0] S_CRD   = 3'd2;
    localparam logic [2:0] S_CWR   = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    localparam logic [2:0] PH_FLAG   = 3'd0;
    localparam logic [2:0] PH_LIT    = 3'd1;
    localparam logic [2:0] PH_OFFSEL = 3'd2;
    localparam logic [2:0] PH_OFF7   = 3'd3;
    localparam logic [2:0] PH_OFF11  = 3'd4;
    localparam logic [2:0] PH_LENA   = 3'd5;
    localparam logic [2:0] PH_LENB   = 3'd6;
    localparam logic [2:0] PH_LENEXT = 3'd7;

    localparam logic [1:0] RUN = 2'd0;
    localparam logic [1:0] ENDED = 2'd1;
    localparam logic [1:0] FAILED = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [2:0] ph_reg, ph_next;
    logic [1:0] stop_reg, stop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_FLAG;
            stop_reg  <= RUN;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            stop_reg  <= stop_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic go_copy;
        logic go_stop;
        cmd        = '0;
        state_next = state_reg;
        ph_next    = ph_reg;
        stop_next  = stop_reg;
        go_copy    = 1'b0;
        go_stop    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stop_reg == RUN)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                unique case (ph_reg)
                    PH_FLAG:
                    begin
                        cmd.consume = 1'b1;
                        if (st.bit_in)
                        begin
                            ph_next = PH_OFFSEL;
                        end
                        else
                        begin
                            cmd.fstart = 1'b1;
                            cmd.fbits  = 4'd8;
                            ph_next    = PH_LIT;
                        end
                    end
                    PH_OFFSEL:
                    begin
                        cmd.consume = 1'b1;
                        cmd.fstart  = 1'b1;
                        if (st.bit_in)
                        begin
                            cmd.fbits = 4'd7;
                            ph_next   = PH_OFF7;
                        end
                        else
                        begin
                            cmd.fbits = 4'd11;
                            ph_next   = PH_OFF11;
                        end
                    end
                    default:
                    begin
                        if (!st.fdone)
                        begin
                            cmd.consume   = 1'b1;
                            cmd.acc_shift = 1'b1;
                        end
                        else if (ph_reg == PH_LIT)
                        begin
                            if (st.emit_ok)
                            begin
                                cmd.consume   = 1'b1;
                                cmd.lit_wr    = 1'b1;
                                cmd.emit      = 1'b1;
                                cmd.emit_kind = KIND_DATA;
                                ph_next       = PH_FLAG;
                            end
                        end
                        else if (ph_reg == PH_OFF7 || ph_reg == PH_OFF11)
                        begin
                            if (ph_reg == PH_OFF7 && st.acc_new == '0)
                            begin
                                if (st.emit_ok)
                                begin
                                    cmd.consume   = 1'b1;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_END;
                                    stop_next     = ENDED;
                                    go_stop       = 1'b1;
                                end
                            end
                            else if (st.off_bad)
                            begin
                                if (st.emit_ok)
                                begin
                                    cmd.consume   = 1'b1;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_ERR;
                                    stop_next     = FAILED;
                                    go_stop       = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.consume  = 1'b1;
                                cmd.off_load = 1'b1;
                                cmd.fstart   = 1'b1;
                                cmd.fbits    = 4'd2;
                                ph_next      = PH_LENA;
                            end
                        end
                        else if (ph_reg == PH_LENA || ph_reg == PH_LENB)
                        begin
                            cmd.consume = 1'b1;
                            if (st.acc_new[1:0] != 2'b11)
                            begin
                                cmd.copy_start = 1'b1;
                                cmd.copy_sel   = (ph_reg == PH_LENA) ? COPY_SHORT : COPY_MID;
                                go_copy        = 1'b1;
                            end
                            else
                            begin
                                cmd.fstart = 1'b1;
                                if (ph_reg == PH_LENA)
                                begin
                                    cmd.fbits = 4'd2;
                                    ph_next   = PH_LENB;
                                end
                                else
                                begin
                                    cmd.ext_init = 1'b1;
                                    cmd.fbits    = 4'd4;
                                    ph_next      = PH_LENEXT;
                                end
                            end
                        end
                        else
                        begin
                            // extension nibble
                            if ((st.acc_new[3:0] != 4'hf && st.ext_sum_over)
                                || (st.acc_new[3:0] == 4'hf && st.ext_add_over))
                            begin
                                if (st.emit_ok)
                                begin
                                    cmd.consume   = 1'b1;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = KIND_ERR;
                                    stop_next     = FAILED;
                                    go_stop       = 1'b1;
                                end
                            end
                            else if (st.acc_new[3:0] != 4'hf)
                            begin
                                cmd.consume    = 1'b1;
                                cmd.copy_start = 1'b1;
                                cmd.copy_sel   = COPY_EXT;
                                go_copy        = 1'b1;
                            end
                            else
                            begin
                                cmd.consume = 1'b1;
                                cmd.ext_add = 1'b1;
                                cmd.fstart  = 1'b1;
                                cmd.fbits   = 4'd4;
                            end
                        end
                    end
                endcase
                if (cmd.consume)
                begin
                    if (go_copy)
                    begin
                        state_next = S_CRD;
                    end
                    else if (go_stop || st.bcnt_last)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_CRD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_CWR;
            end
            S_CWR:
            begin
                if (st.emit_ok)
                begin
                    cmd.copy_wr   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DATA;
                    if (st.copy_last)
                    begin
                        ph_next    = PH_FLAG;
                        state_next = st.bcnt_zero ? S_FLUSH : S_BIT;
                    end
                    else
                    begin
                        state_next = S_CRD;
                    end
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

### hdl/lzs_dp.sv
// bit shifter, field registers, history ring and result buffering
module lzs_dp #(
    parameter int HISTORY_DEPTH = 2048,
    parameter int MAX_MATCH     = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    in_byte,
    input  lzs_pkg::cmd_t cmd,
    output lzs_pkg::sts_t st,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic [1:0]    kind,
    output logic          last_of_run
);
    import lzs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [7:0]       sh_reg;
    logic [3:0]       bcnt_reg;
    logic [OFF_W-1:0] acc_reg;
    logic [3:0]       brem_reg;
    logic [OFF_W-1:0] off_reg;
    logic [LEN_W-1:0] len_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    src_reg;
    logic [CW-1:0]    hcnt_reg;
    logic [6:0]       rcnt_reg;
    logic             pend_v_reg;
    logic [7:0]       pend_byte_reg;
    logic [1:0]       pend_kind_reg;
    logic             ov_reg;
    logic [7:0]       obyte_reg;
    logic [1:0]       okind_reg;
    logic             olast_reg;

    logic [OFF_W-1:0] acc_new;
    logic [7:0]       rdata;
    logic             can_push;
    logic             room;
    logic             take;
    logic             push;
    logic [7:0]       emit_byte;
    logic [LEN_W-1:0] copy_len;
    logic [11:0]      wp12;
    logic [11:0]      off12;
    logic [11:0]      src12;
    logic [7:0]       ext_sum;
    logic [7:0]       ext_add;
    logic             we;
    logic [7:0]       wd;

    assign acc_new  = {acc_reg[OFF_W-2:0], sh_reg[7]};
    assign can_push = !ov_reg || !out_stall;
    assign room     = (rcnt_reg < 7'(RESULT_CAP));
    assign take     = cmd.emit && room;
    assign push     = (take && pend_v_reg) || (cmd.flush && pend_v_reg);
    assign ext_sum  = {1'b0, len_reg} + {4'd0, acc_new[3:0]};
    assign ext_add  = {1'b0, len_reg} + 8'd15;

    assign st.bit_in       = sh_reg[7];
    assign st.acc_new      = acc_new;
    assign st.fdone        = (brem_reg <= 4'd1);
    assign st.bcnt_last    = (bcnt_reg == 4'd1);
    assign st.bcnt_zero    = (bcnt_reg == 4'd0);
    assign st.off_bad      = (acc_new == '0) || ({1'b0, acc_new} > 12'(hcnt_reg));
    assign st.ext_sum_over = (ext_sum > 8'(MAX_MATCH));
    assign st.ext_add_over = (ext_add > 8'(MAX_MATCH));
    assign st.copy_last    = (len_reg == 7'd1);
    assign st.emit_ok      = !room || !pend_v_reg || can_push;
    assign st.flush_ok     = !pend_v_reg || can_push;

    always_comb
    begin
        case (cmd.copy_sel)
            COPY_SHORT: copy_len = {5'd0, acc_new[1:0]} + 7'd2;
            COPY_MID:   copy_len = {5'd0, acc_new[1:0]} + 7'd5;
            default:    copy_len = ext_sum[LEN_W-1:0];
        endcase
    end

    // copy source sits offset bytes behind the write pointer, modulo the ring
    assign wp12  = 12'(wp_reg);
    assign off12 = {1'b0, off_reg};
    assign src12 = (wp12 >= off12) ? (wp12 - off12)
                                   : (wp12 + 12'(HISTORY_DEPTH) - off12);

    assign emit_byte = cmd.lit_wr ? acc_new[7:0] : (cmd.copy_wr ? rdata : 8'd0);
    assign we        = cmd.lit_wr || cmd.copy_wr;
    assign wd        = cmd.lit_wr ? acc_new[7:0] : rdata;

    lzs_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (we),
        .waddr(wp_reg),
        .wdata(wd),
        .re   (cmd.copy_rd),
        .raddr(src_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcnt_reg   <= '0;
            acc_reg    <= '0;
            brem_reg   <= '0;
            off_reg    <= '0;
            len_reg    <= '0;
            wp_reg     <= '0;
            src_reg    <= '0;
            hcnt_reg   <= '0;
            rcnt_reg   <= '0;
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bcnt_reg <= 4'd8;
                rcnt_reg <= '0;
            end
            else if (cmd.consume)
            begin
                bcnt_reg <= bcnt_reg - 4'd1;
            end
            if (cmd.fstart)
            begin
                acc_reg  <= '0;
                brem_reg <= cmd.fbits;
            end
            else if (cmd.acc_shift)
            begin
                acc_reg  <= acc_new;
                brem_reg <= brem_reg - 4'd1;
            end
            if (cmd.off_load)
            begin
                off_reg <= acc_new;
            end
            if (cmd.ext_init)
            begin
                len_reg <= 7'd8;
            end
            else if (cmd.ext_add)
            begin
                len_reg <= ext_add[LEN_W-1:0];
            end
            else if (cmd.copy_start)
            begin
                len_reg <= copy_len;
                src_reg <= src12[AW-1:0];
            end
            else if (cmd.copy_wr)
            begin
                len_reg <= len_reg - 7'd1;
                src_reg <= (src_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : src_reg + AW'(1);
            end
            if (we)
            begin
                wp_reg <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (hcnt_reg < CW'(HISTORY_DEPTH))
                begin
                    hcnt_reg <= hcnt_reg + CW'(1);
                end
            end
            if (take)
            begin
                rcnt_reg   <= rcnt_reg + 7'd1;
                pend_v_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_v_reg <= 1'b0;
            end
            if (push)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sh_reg <= in_byte;
        end
        else if (cmd.consume)
        begin
            sh_reg <= {sh_reg[6:0], 1'b0};
        end
        if (take)
        begin
            pend_byte_reg <= emit_byte;
            pend_kind_reg <= cmd.emit_kind;
        end
        if (push)
        begin
            obyte_reg <= pend_byte_reg;
            okind_reg <= pend_kind_reg;
            olast_reg <= cmd.flush;
        end
    end

    assign out_valid   = ov_reg;
    assign out_byte    = obyte_reg;
    assign kind        = okind_reg;
    assign last_of_run = olast_reg;
endmodule

### hdl/lzs_stream_decompressor_top.sv
// lzs stream decompressor top level
//
//   channel   signals                          direction
//   input     in_valid, in_stall, in_byte      compressed bytes in
//   output    out_valid, out_stall,            decoded results out
//             out_byte, kind, last_of_run
//
// each compressed bit is consumed in its own parser step, each byte copied from history
// takes a ring read then a ring write, a flush releases the last result, and the parser
// returns to idle before taking the next byte; copy speed is set by the single ring port pair.
// reset clears parser, pointers and result buffers; the ring needs no clearing.
// a stalled output holds the parser at the next result; input waits meanwhile.
module lzs_stream_decompressor_top #(
    parameter int HISTORY_DEPTH = 2048,
    parameter int MAX_MATCH     = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last_of_run
);
    import lzs_pkg::*;

    cmd_t cmd;
    sts_t st;

    lzs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .st      (st),
        .cmd     (cmd)
    );

    lzs_dp #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .MAX_MATCH    (MAX_MATCH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .kind       (kind),
        .last_of_run(last_of_run)
    );
endmodule
